// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the voxel face culling rtl
// no dependencies; the property forms compile to nothing when SYNTH is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/core/vfc_pkg.sv =====
// shared types and constants of the voxel face culling block
// no dependencies
`default_nettype none

package vfc_pkg;

    // default chunk dimensions
    localparam int SIZE_X_DEF = 16;
    localparam int SIZE_Y_DEF = 256;
    localparam int SIZE_Z_DEF = 16;

    // coordinate field widths
    localparam int X_W = 4;
    localparam int Y_W = 8;
    localparam int Z_W = 4;

    localparam int NUM_DIRS    = 6;
    localparam int DIR_W       = 3;
    localparam int QUEUE_DEPTH = 4;

    // request kinds
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // face directions
    localparam logic [DIR_W-1:0] DIR_PY = 3'd0;
    localparam logic [DIR_W-1:0] DIR_NY = 3'd1;
    localparam logic [DIR_W-1:0] DIR_PZ = 3'd2;
    localparam logic [DIR_W-1:0] DIR_NZ = 3'd3;
    localparam logic [DIR_W-1:0] DIR_PX = 3'd4;
    localparam logic [DIR_W-1:0] DIR_NX = 3'd5;

    // classified request as it travels through the queue
    typedef struct packed {
        logic                cmd;
        logic                in_chunk;
        logic [NUM_DIRS-1:0] nbr_in;
        logic [X_W-1:0]      x;
        logic [Y_W-1:0]      y;
        logic [Z_W-1:0]      z;
        logic                solid;
        logic                opaque;
    } t_item;

    // back end status
    typedef struct packed {
        logic idle;
        logic emit;
    } t_back_stat;

endpackage

`default_nettype wire

// ===== rtl/core/vfc_front.sv =====
// front end: takes requests and classifies them (chunk bounds, neighbours inside)
// depends on vfc_pkg
`default_nettype none

module vfc_front #(
    parameter int SIZE_X = vfc_pkg::SIZE_X_DEF,
    parameter int SIZE_Y = vfc_pkg::SIZE_Y_DEF,
    parameter int SIZE_Z = vfc_pkg::SIZE_Z_DEF
) (
    input  wire logic                   i_valid,
    input  wire logic                   i_cmd,
    input  wire logic [vfc_pkg::X_W-1:0] i_x,
    input  wire logic [vfc_pkg::Y_W-1:0] i_y,
    input  wire logic [vfc_pkg::Z_W-1:0] i_z,
    input  wire logic                   i_solid,
    input  wire logic                   i_opaque,
    input  wire logic                   i_q_full,
    output logic                        o_ready,
    output logic                        o_push,
    output vfc_pkg::t_item              o_item
);

    logic w_in_x;
    logic w_in_y;
    logic w_in_z;

    assign w_in_x = int'(i_x) < SIZE_X;
    assign w_in_y = int'(i_y) < SIZE_Y;
    assign w_in_z = int'(i_z) < SIZE_Z;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        o_item          = '0;
        o_item.cmd      = i_cmd;
        o_item.in_chunk = w_in_x && w_in_y && w_in_z;
        o_item.x        = i_x;
        o_item.y        = i_y;
        o_item.z        = i_z;
        o_item.solid    = i_solid;
        o_item.opaque   = i_opaque;
        // below-zero neighbours fall outside the chunk
        o_item.nbr_in[vfc_pkg::DIR_PY] = (int'(i_y) + 1) < SIZE_Y;
        o_item.nbr_in[vfc_pkg::DIR_NY] = i_y != '0;
        o_item.nbr_in[vfc_pkg::DIR_PZ] = (int'(i_z) + 1) < SIZE_Z;
        o_item.nbr_in[vfc_pkg::DIR_NZ] = i_z != '0;
        o_item.nbr_in[vfc_pkg::DIR_PX] = (int'(i_x) + 1) < SIZE_X;
        o_item.nbr_in[vfc_pkg::DIR_NX] = i_x != '0;
    end

endmodule

`default_nettype wire

// ===== rtl/core/vfc_queue.sv =====
// short request queue between front and back end
// depends on vfc_pkg
`default_nettype none

module vfc_queue #(
    parameter int DEPTH = vfc_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire vfc_pkg::t_item i_item,
    input  wire logic           i_pop,
    output vfc_pkg::t_item      o_item,
    output logic                o_empty,
    output logic                o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    vfc_pkg::t_item r_buf [DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic [PW-1:0]  n_wr_ptr;
    logic [PW-1:0]  n_rd_ptr;
    logic [CW-1:0]  n_count;

    assign o_empty = r_count == '0;
    assign o_full  = r_count == CW'(DEPTH);
    assign o_item  = r_buf[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : PW'(r_wr_ptr + 1'b1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : PW'(r_rd_ptr + 1'b1);
        end
        if (i_push && !i_pop) begin
            n_count = CW'(r_count + 1'b1);
        end else if (i_pop && !i_push) begin
            n_count = CW'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/vfc_back.sv =====
// back end: voxel store, neighbour read sequencer and face output register
// depends on vfc_pkg
`default_nettype none

module vfc_back #(
    parameter int SIZE_X = vfc_pkg::SIZE_X_DEF,
    parameter int SIZE_Y = vfc_pkg::SIZE_Y_DEF,
    parameter int SIZE_Z = vfc_pkg::SIZE_Z_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire vfc_pkg::t_item           i_item,
    input  wire logic                     i_empty,
    output logic                          o_pop,
    input  wire logic                     i_out_ready,
    output logic                          o_out_valid,
    output logic [vfc_pkg::DIR_W-1:0]     o_out_dir,
    output logic [vfc_pkg::X_W-1:0]       o_out_x,
    output logic [vfc_pkg::Y_W-1:0]       o_out_y,
    output logic [vfc_pkg::Z_W-1:0]       o_out_z,
    output logic                          o_out_last,
    output vfc_pkg::t_back_stat           o_stat
);

    localparam int DEPTH = SIZE_X * SIZE_Y * SIZE_Z;
    localparam int AW    = $clog2(DEPTH);
    localparam int OFF_X = 1;
    localparam int OFF_Z = SIZE_X;
    localparam int OFF_Y = SIZE_X * SIZE_Z;
    localparam int ND    = vfc_pkg::NUM_DIRS;
    localparam int DW    = vfc_pkg::DIR_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CTR  = 2'd1;
    localparam logic [1:0] S_NBR  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    // bit 0 solid, bit 1 opaque
    logic [1:0]            r_mem [DEPTH];
    logic [1:0]            r_rd_data;

    logic [1:0]            r_state;
    logic [1:0]            n_state;
    logic [AW-1:0]         r_addr;
    logic [AW-1:0]         n_addr;
    logic [ND-1:0]         r_nbr_in;
    logic [ND-1:0]         n_nbr_in;
    logic [ND-1:0]         r_open;
    logic [ND-1:0]         n_open;
    logic [DW-1:0]         r_dir;
    logic [DW-1:0]         n_dir;
    logic [vfc_pkg::X_W-1:0] r_x;
    logic [vfc_pkg::Y_W-1:0] r_y;
    logic [vfc_pkg::Z_W-1:0] r_z;

    logic                  r_out_valid;
    logic [DW-1:0]         r_out_dir;
    logic                  r_out_last;
    logic [vfc_pkg::X_W-1:0] r_out_x;
    logic [vfc_pkg::Y_W-1:0] r_out_y;
    logic [vfc_pkg::Z_W-1:0] r_out_z;

    logic                  w_wr_en;
    logic [AW-1:0]         w_wr_addr;
    logic [1:0]            w_wr_data;
    logic                  w_rd_en;
    logic [AW-1:0]         w_rd_addr;
    logic [AW-1:0]         w_item_addr;
    logic                  w_out_free;
    logic                  w_load;
    logic [DW-1:0]         w_sel;
    logic                  w_last;
    logic [DW-1:0]         w_next_dir;

    // linear index x + SIZE_X * (z + SIZE_Z * y)
    assign w_item_addr = AW'(int'(i_item.x) + SIZE_X * (int'(i_item.z) +
                                                         SIZE_Z * int'(i_item.y)));

    function automatic logic [AW-1:0] nbr_addr(input logic [AW-1:0] base,
                                               input logic [DW-1:0] dir);
        logic [AW-1:0] res;
        begin
            case (dir)
                vfc_pkg::DIR_PY: res = AW'(base + AW'(OFF_Y));
                vfc_pkg::DIR_NY: res = AW'(base - AW'(OFF_Y));
                vfc_pkg::DIR_PZ: res = AW'(base + AW'(OFF_Z));
                vfc_pkg::DIR_NZ: res = AW'(base - AW'(OFF_Z));
                vfc_pkg::DIR_PX: res = AW'(base + AW'(OFF_X));
                vfc_pkg::DIR_NX: res = AW'(base - AW'(OFF_X));
                default:         res = base;
            endcase
            return res;
        end
    endfunction

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_next_dir = DW'(r_dir + 1'b1);

    // lowest open direction and whether it is the final one
    always_comb begin
        logic [ND-1:0] rest;
        w_sel = '0;
        for (int i = ND - 1; i >= 0; i--) begin
            if (r_open[i]) begin
                w_sel = DW'(i);
            end
        end
        rest = r_open;
        rest[w_sel] = 1'b0;
        w_last = rest == '0;
    end

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_nbr_in  = r_nbr_in;
        n_open    = r_open;
        n_dir     = r_dir;
        o_pop     = 1'b0;
        w_wr_en   = 1'b0;
        w_wr_addr = w_item_addr;
        w_wr_data = {i_item.opaque, i_item.solid};
        w_rd_en   = 1'b0;
        w_rd_addr = w_item_addr;
        w_load    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    if (i_item.in_chunk) begin
                        if (i_item.cmd == vfc_pkg::CMD_WRITE) begin
                            w_wr_en = 1'b1;
                        end else begin
                            w_rd_en  = 1'b1;
                            n_addr   = w_item_addr;
                            n_nbr_in = i_item.nbr_in;
                            n_state  = S_CTR;
                        end
                    end
                end
            end
            S_CTR: begin
                n_open = '0;
                if (!r_rd_data[0]) begin
                    n_state = S_IDLE;
                end else begin
                    n_dir     = vfc_pkg::DIR_PY;
                    w_rd_en   = r_nbr_in[vfc_pkg::DIR_PY];
                    w_rd_addr = nbr_addr(r_addr, vfc_pkg::DIR_PY);
                    n_state   = S_NBR;
                end
            end
            S_NBR: begin
                n_open[r_dir] = !(r_nbr_in[r_dir] && r_rd_data[1]);
                if (r_dir == vfc_pkg::DIR_NX) begin
                    n_state = S_EMIT;
                end else begin
                    n_dir     = w_next_dir;
                    w_rd_en   = r_nbr_in[w_next_dir];
                    w_rd_addr = nbr_addr(r_addr, w_next_dir);
                end
            end
            S_EMIT: begin
                if (r_open == '0) begin
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    w_load        = 1'b1;
                    n_open[w_sel] = 1'b0;
                    if (w_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_nbr_in <= n_nbr_in;
        r_open   <= n_open;
        r_dir    <= n_dir;
        if (o_pop) begin
            r_x <= i_item.x;
            r_y <= i_item.y;
            r_z <= i_item.z;
        end
        if (w_load) begin
            r_out_dir  <= w_sel;
            r_out_last <= w_last;
            r_out_x    <= r_x;
            r_out_y    <= r_y;
            r_out_z    <= r_z;
        end
    end

    // voxel store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_dir   = r_out_dir;
    assign o_out_x     = r_out_x;
    assign o_out_y     = r_out_y;
    assign o_out_z     = r_out_z;
    assign o_out_last  = r_out_last;
    assign o_stat.idle = r_state == S_IDLE;
    assign o_stat.emit = r_state == S_EMIT;

endmodule

`default_nettype wire

// ===== rtl/core/voxel_face_culling.sv =====
// voxel face culling top level: front end, request queue, back end with voxel store
// depends on vfc_pkg, vfc_front, vfc_queue, vfc_back and assert_macros.svh
//
// usage:
//   the slave stream carries requests. tuser is the kind (0 write, 1 query),
//   tdata packs pos_x, pos_y, pos_z, is_solid, is_opaque. a write loads the
//   solid and opaque bits of one voxel and returns nothing. a query returns
//   one face request per open side of a solid voxel, order +Y -Y +Z -Z +X -X,
//   with tlast on the final face; air or out-of-chunk voxels return nothing
//   sequencing:
//   a write or an out-of-chunk request is taken from the queue with no store read. a query
//   reads the center and ends there for air; for a solid voxel it then reads the six
//   neighbours: the store has one read port, so center and six neighbours go one per cycle.
//   faces then leave one per cycle while the master takes them, one per open side.
//   reset and stall:
//   reset empties the queue and the sequencer; voxel contents are undefined
//   until written. a stalled master holds the face register, the back end
//   waits, and the front keeps taking requests until the 4-entry queue fills
`default_nettype none

module voxel_face_culling #(
    parameter int SIZE_X = vfc_pkg::SIZE_X_DEF,
    parameter int SIZE_Y = vfc_pkg::SIZE_Y_DEF,
    parameter int SIZE_Z = vfc_pkg::SIZE_Z_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // pos_x[3:0] pos_y[11:4] pos_z[15:12]
                                             // is_solid[16] is_opaque[17], rest zero
    input  wire logic [0:0]  s_axis_tuser,   // command[0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // direction[2:0] origin_x[6:3]
                                             // origin_y[14:7] origin_z[18:15], rest zero
    output logic             m_axis_tlast    // last_face
);

`include "assert_macros.svh"

    // classified request into the queue
    vfc_pkg::t_item      w_front_item;
    logic                w_push;
    // queue head into the back end
    vfc_pkg::t_item      w_q_item;
    logic                w_q_empty;
    logic                w_q_full;
    logic                w_q_pop;
    vfc_pkg::t_back_stat w_stat;
    // face register fields
    logic [vfc_pkg::DIR_W-1:0] w_dir;
    logic [vfc_pkg::X_W-1:0]   w_ox;
    logic [vfc_pkg::Y_W-1:0]   w_oy;
    logic [vfc_pkg::Z_W-1:0]   w_oz;

    vfc_front #(
        .SIZE_X (SIZE_X),
        .SIZE_Y (SIZE_Y),
        .SIZE_Z (SIZE_Z)
    ) u_front (
        .i_valid  (s_axis_tvalid),
        .i_cmd    (s_axis_tuser[0]),
        .i_x      (s_axis_tdata[3:0]),
        .i_y      (s_axis_tdata[11:4]),
        .i_z      (s_axis_tdata[15:12]),
        .i_solid  (s_axis_tdata[16]),
        .i_opaque (s_axis_tdata[17]),
        .i_q_full (w_q_full),
        .o_ready  (s_axis_tready),
        .o_push   (w_push),
        .o_item   (w_front_item)
    );

    vfc_queue #(
        .DEPTH (vfc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_q_pop),
        .o_item  (w_q_item),
        .o_empty (w_q_empty),
        .o_full  (w_q_full)
    );

    vfc_back #(
        .SIZE_X (SIZE_X),
        .SIZE_Y (SIZE_Y),
        .SIZE_Z (SIZE_Z)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (w_q_item),
        .i_empty     (w_q_empty),
        .o_pop       (w_q_pop),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_dir   (w_dir),
        .o_out_x     (w_ox),
        .o_out_y     (w_oy),
        .o_out_z     (w_oz),
        .o_out_last  (m_axis_tlast),
        .o_stat      (w_stat)
    );

    assign m_axis_tdata = {5'd0, w_oz, w_oy, w_ox, w_dir};

    // the back end only takes a request that is really in the queue
    `ASSERT_IMPLY(a_pop_nonempty, i_clk, i_rst_n, w_q_pop, !w_q_empty, "pop from empty queue")
    // a new face only appears following the emit state
    `ASSERT_IMPLY(a_face_from_emit, i_clk, i_rst_n, $rose(m_axis_tvalid), $past(w_stat.emit), "face without emit")
    // emitted direction is a real face
    `ASSERT_IMPLY(a_dir_range, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[2:0] <= vfc_pkg::DIR_NX, "bad face direction")
    // the sequencer is never idle and in the emit state together
    `ASSERT_ALWAYS(a_idle_emit, i_clk, i_rst_n, !(w_stat.idle && w_stat.emit), "idle and emit together")

endmodule

`default_nettype wire

// ===== tb/sv/voxel_face_culling_tb.sv =====
// self-checking testbench for voxel_face_culling: drives write and query requests on the
// slave stream and checks every face request on the master stream against its own model
// depends on vfc_pkg and the voxel_face_culling rtl
`timescale 1ns / 100ps

module voxel_face_culling_tb;

    localparam int CHUNK_VOXELS  = vfc_pkg::SIZE_X_DEF * vfc_pkg::SIZE_Y_DEF *
                                   vfc_pkg::SIZE_Z_DEF;
    localparam int ITEM_TARGET   = 430;
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam int STALL_LIMIT   = 2000;  // cycles with no handshake at all
    localparam int SETTLE_CYCLES = 80;    // margin for a full queue of faceless queries to drain
    localparam int PRINT_LIMIT   = 50;

    // one expected face request
    typedef struct packed {
        logic [vfc_pkg::DIR_W-1:0] dir;
        logic [vfc_pkg::X_W-1:0]   x;
        logic [vfc_pkg::Y_W-1:0]   y;
        logic [vfc_pkg::Z_W-1:0]   z;
        logic                      last;
    } t_face;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // pos_x[3:0] pos_y[11:4] pos_z[15:12] solid[16] opaque[17]
    logic [0:0]  s_axis_tuser = '0;   // command[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // direction[2:0] origin_x[6:3] origin_y[14:7] origin_z[18:15]
    logic        m_axis_tlast;        // last_face

    // shadow of the chunk store: bit 0 solid, bit 1 opaque
    logic [1:0]  voxel_mem [CHUNK_VOXELS];
    bit          voxel_written [CHUNK_VOXELS];
    t_face       expected_faces [$];
    int          prepared_voxels [$];   // queried voxels whose neighbourhood is loaded

    int          requests_sent = 0;
    int          mismatches = 0;
    bit          calm = 1'b0;           // no idling on either side while set
    int          hold_req = 0;          // bumped to ask the receiver for a long hold-off
    int          hold_seen = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;

    voxel_face_culling i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // chunk geometry helpers
    // ------------------------------------------------------------------

    function automatic bit in_chunk(input int x, input int y, input int z);
        return x >= 0 && x < vfc_pkg::SIZE_X_DEF && y >= 0 && y < vfc_pkg::SIZE_Y_DEF &&
               z >= 0 && z < vfc_pkg::SIZE_Z_DEF;
    endfunction

    function automatic int vox_index(input int x, input int y, input int z);
        return (y * vfc_pkg::SIZE_Z_DEF + z) * vfc_pkg::SIZE_X_DEF + x;
    endfunction

    function automatic void neighbour_of(input logic [vfc_pkg::DIR_W-1:0] dir, input int x,
                                         input int y, input int z, output int nx,
                                         output int ny, output int nz);
        nx = x;
        ny = y;
        nz = z;
        case (dir)
            vfc_pkg::DIR_PY: ny = y + 1;
            vfc_pkg::DIR_NY: ny = y - 1;
            vfc_pkg::DIR_PZ: nz = z + 1;
            vfc_pkg::DIR_NZ: nz = z - 1;
            vfc_pkg::DIR_PX: nx = x + 1;
            vfc_pkg::DIR_NX: nx = x - 1;
            default: ;
        endcase
    endfunction

    // a voxel may be queried once it and every neighbour inside the chunk are loaded
    function automatic bit neighbourhood_loaded(input int x, input int y, input int z);
        int nx, ny, nz;
        bit ok;
        ok = voxel_written[vox_index(x, y, z)];
        for (int d = 0; d < vfc_pkg::NUM_DIRS; d++) begin
            neighbour_of(d[vfc_pkg::DIR_W-1:0], x, y, z, nx, ny, nz);
            if (in_chunk(nx, ny, nz) && !voxel_written[vox_index(nx, ny, nz)])
                ok = 1'b0;
        end
        return ok;
    endfunction

    // edges of the chunk turn up far more often than a flat draw would give
    function automatic int pick_coord(input int top);
        case ($urandom_range(9))
            0: return 0;
            1: return top;
            default: return $urandom_range(top);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // face prediction: one face per side whose neighbour is outside or not opaque,
    // order +Y -Y +Z -Z +X -X, last flag on the final one; air gives nothing
    // ------------------------------------------------------------------

    function automatic void predict_faces(input int x, input int y, input int z);
        t_face found [$];
        t_face f;
        int    nx, ny, nz;
        if (!voxel_mem[vox_index(x, y, z)][0])
            return;
        for (int d = 0; d < vfc_pkg::NUM_DIRS; d++) begin
            neighbour_of(d[vfc_pkg::DIR_W-1:0], x, y, z, nx, ny, nz);
            if (!(in_chunk(nx, ny, nz) && voxel_mem[vox_index(nx, ny, nz)][1])) begin
                f.dir  = d[vfc_pkg::DIR_W-1:0];
                f.x    = x[vfc_pkg::X_W-1:0];
                f.y    = y[vfc_pkg::Y_W-1:0];
                f.z    = z[vfc_pkg::Z_W-1:0];
                f.last = 1'b0;
                found  = {found, f};
            end
        end
        if (found.size() > 0)
            found[found.size() - 1].last = 1'b1;
        foreach (found[i])
            expected_faces = {expected_faces, found[i]};
    endfunction

    // ------------------------------------------------------------------
    // request driver: optional gap, then hold the request until it is taken
    // ------------------------------------------------------------------

    task automatic send_request(input logic cmd, input int x, input int y, input int z,
                                input logic solid, input logic opaque);
        if (!calm && $urandom_range(99) < 10) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {6'b0, opaque, solid, z[vfc_pkg::Z_W-1:0], y[vfc_pkg::Y_W-1:0],
                          x[vfc_pkg::X_W-1:0]};
        do @(posedge i_clk); while (!s_axis_tready);
        requests_sent++;
        if (cmd == vfc_pkg::CMD_WRITE) begin
            voxel_mem[vox_index(x, y, z)]     = {opaque, solid};
            voxel_written[vox_index(x, y, z)] = 1'b1;
        end else begin
            predict_faces(x, y, z);
        end
    endtask

    task automatic query_voxel(input int x, input int y, input int z);
        send_request(vfc_pkg::CMD_QUERY, x, y, z, 1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    // load a voxel and its in-chunk neighbours with random contents; with keep_old
    // set, neighbours loaded earlier keep what they hold
    task automatic load_neighbourhood(input int x, input int y, input int z, input bit keep_old);
        int  nx, ny, nz;
        bit  center_last;
        center_last = 1'($urandom_range(1));
        if (!center_last)
            send_request(vfc_pkg::CMD_WRITE, x, y, z, $urandom_range(99) < 80,
                         1'($urandom_range(1)));
        for (int d = 0; d < vfc_pkg::NUM_DIRS; d++) begin
            neighbour_of(d[vfc_pkg::DIR_W-1:0], x, y, z, nx, ny, nz);
            if (in_chunk(nx, ny, nz) && !(keep_old && voxel_written[vox_index(nx, ny, nz)]))
                send_request(vfc_pkg::CMD_WRITE, nx, ny, nz, 1'($urandom_range(1)),
                             $urandom_range(99) < 65);
        end
        if (center_last)
            send_request(vfc_pkg::CMD_WRITE, x, y, z, $urandom_range(99) < 80,
                         1'($urandom_range(1)));
    endtask

    task automatic wait_for_drain();
        while (expected_faces.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // directed tests
    // ------------------------------------------------------------------

    // low corner shows all six sides, high corner only its three outer sides;
    // the second query carries set data bits, which must not matter
    task automatic test_corner_voxels();
        send_request(vfc_pkg::CMD_WRITE, 0, 0, 0, 1'b1, 1'b1);
        send_request(vfc_pkg::CMD_WRITE, 1, 0, 0, 1'b1, 1'b0);
        send_request(vfc_pkg::CMD_WRITE, 0, 1, 0, 1'b1, 1'b0);
        send_request(vfc_pkg::CMD_WRITE, 0, 0, 1, 1'b1, 1'b0);
        send_request(vfc_pkg::CMD_QUERY, 0, 0, 0, 1'b0, 1'b0);
        send_request(vfc_pkg::CMD_WRITE, 15, 255, 15, 1'b1, 1'b0);
        send_request(vfc_pkg::CMD_WRITE, 14, 255, 15, 1'b1, 1'b1);
        send_request(vfc_pkg::CMD_WRITE, 15, 254, 15, 1'b1, 1'b1);
        send_request(vfc_pkg::CMD_WRITE, 15, 255, 14, 1'b1, 1'b1);
        send_request(vfc_pkg::CMD_QUERY, 15, 255, 15, 1'b1, 1'b1);
        prepared_voxels = {prepared_voxels, vox_index(0, 0, 0)};
        prepared_voxels = {prepared_voxels, vox_index(15, 255, 15)};
    endtask

    // solid voxel walled in by opaque air: no faces at all
    task automatic test_enclosed_voxel();
        int nx, ny, nz;
        send_request(vfc_pkg::CMD_WRITE, 7, 100, 7, 1'b1, 1'b1);
        for (int d = 0; d < vfc_pkg::NUM_DIRS; d++) begin
            neighbour_of(d[vfc_pkg::DIR_W-1:0], 7, 100, 7, nx, ny, nz);
            send_request(vfc_pkg::CMD_WRITE, nx, ny, nz, 1'b0, 1'b1);
        end
        send_request(vfc_pkg::CMD_QUERY, 7, 100, 7, 1'b0, 1'b1);
        prepared_voxels = {prepared_voxels, vox_index(7, 100, 7)};
    endtask

    // air gives nothing, also when the query carries a set solid bit
    task automatic test_air_voxel();
        send_request(vfc_pkg::CMD_WRITE, 7, 100, 7, 1'b0, 1'b0);
        send_request(vfc_pkg::CMD_QUERY, 7, 100, 7, 1'b1, 1'b0);
    endtask

    // one transparent neighbour opens exactly one side, flagged last
    task automatic test_partial_cover();
        send_request(vfc_pkg::CMD_WRITE, 8, 100, 7, 1'b1, 1'b0);
        send_request(vfc_pkg::CMD_WRITE, 7, 100, 7, 1'b1, 1'b0);
        send_request(vfc_pkg::CMD_QUERY, 7, 100, 7, 1'b0, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // random meshing: mostly load-then-query sequences, some requeries, some after a
    // single rewrite, some loose writes and queries
    // ------------------------------------------------------------------

    task automatic test_random_meshing(input int target, input int calm_lo, input int calm_hi);
        int pick, x, y, z, idx, nx, ny, nz;
        while (requests_sent < target) begin
            calm <= requests_sent >= calm_lo && requests_sent < calm_hi;
            pick = $urandom_range(99);
            if (pick < 60 || prepared_voxels.size() == 0) begin
                x = pick_coord(vfc_pkg::SIZE_X_DEF - 1);
                y = pick_coord(vfc_pkg::SIZE_Y_DEF - 1);
                z = pick_coord(vfc_pkg::SIZE_Z_DEF - 1);
                load_neighbourhood(x, y, z, $urandom_range(99) < 30);
                query_voxel(x, y, z);
                prepared_voxels = {prepared_voxels, vox_index(x, y, z)};
            end else if (pick < 85) begin
                idx = prepared_voxels[$urandom_range(prepared_voxels.size() - 1)];
                x = idx % vfc_pkg::SIZE_X_DEF;
                z = (idx / vfc_pkg::SIZE_X_DEF) % vfc_pkg::SIZE_Z_DEF;
                y = idx / (vfc_pkg::SIZE_X_DEF * vfc_pkg::SIZE_Z_DEF);
                if ($urandom_range(1)) begin
                    // rewrite the voxel itself or one of its neighbours
                    pick = $urandom_range(vfc_pkg::NUM_DIRS);
                    neighbour_of(pick[vfc_pkg::DIR_W-1:0], x, y, z, nx, ny, nz);
                    if (pick == vfc_pkg::NUM_DIRS || !in_chunk(nx, ny, nz)) begin
                        nx = x;
                        ny = y;
                        nz = z;
                    end
                    send_request(vfc_pkg::CMD_WRITE, nx, ny, nz, 1'($urandom_range(1)),
                                 1'($urandom_range(1)));
                end
                query_voxel(x, y, z);
            end else begin
                x = $urandom_range(vfc_pkg::SIZE_X_DEF - 1);
                y = $urandom_range(vfc_pkg::SIZE_Y_DEF - 1);
                z = $urandom_range(vfc_pkg::SIZE_Z_DEF - 1);
                if (neighbourhood_loaded(x, y, z))
                    query_voxel(x, y, z);
                else
                    send_request(vfc_pkg::CMD_WRITE, x, y, z, 1'($urandom_range(1)),
                                 1'($urandom_range(1)));
            end
        end
        calm <= 1'b0;
    endtask

    // receiver holds off for a long stretch while requests keep coming, so the
    // queue fills and the slave side stalls
    task automatic test_backpressure();
        int idx;
        hold_req <= hold_req + 1;
        repeat (24) begin
            idx = prepared_voxels[$urandom_range(prepared_voxels.size() - 1)];
            query_voxel(idx % vfc_pkg::SIZE_X_DEF,
                        idx / (vfc_pkg::SIZE_X_DEF * vfc_pkg::SIZE_Z_DEF),
                        (idx / vfc_pkg::SIZE_X_DEF) % vfc_pkg::SIZE_Z_DEF);
        end
    endtask

    // sender goes quiet until every face has been taken
    task automatic test_drain_pause();
        s_axis_tvalid <= 1'b0;
        wait_for_drain();
    endtask

    // ------------------------------------------------------------------
    // receiver: random idling, long hold-off on request
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_seen     <= 0;
            hold_left     <= 0;
        end else if (hold_req != hold_seen) begin
            hold_seen     <= hold_req;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm || $urandom_range(99) >= 10;
        end
    end

    // ------------------------------------------------------------------
    // face checker
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < PRINT_LIMIT)
            $display("%0t: face mismatch on %s: got %0d, expected %0d", $realtime, what, got,
                     want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_face want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_faces.size() == 0) begin
                report_mismatch("unexpected face word", m_axis_tdata, 0);
            end else begin
                want = expected_faces.pop_front();
                if (m_axis_tdata[2:0] !== want.dir)
                    report_mismatch("direction", m_axis_tdata[2:0], want.dir);
                if (m_axis_tdata[6:3] !== want.x)
                    report_mismatch("origin_x", m_axis_tdata[6:3], want.x);
                if (m_axis_tdata[14:7] !== want.y)
                    report_mismatch("origin_y", m_axis_tdata[14:7], want.y);
                if (m_axis_tdata[18:15] !== want.z)
                    report_mismatch("origin_z", m_axis_tdata[18:15], want.z);
                if (m_axis_tdata[23:19] !== 5'b0)
                    report_mismatch("tdata padding", m_axis_tdata[23:19], 0);
                if (m_axis_tlast !== want.last)
                    report_mismatch("last_face", m_axis_tlast, want.last);
            end
        end
    end

    // watchdog: too long without any handshake on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("voxel_face_culling_tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corner_voxels();
        test_enclosed_voxel();
        test_air_voxel();
        test_partial_cover();
        test_drain_pause();
        test_random_meshing(200, 0, 0);
        test_backpressure();
        test_drain_pause();
        test_random_meshing(ITEM_TARGET, 280, 360);

        s_axis_tvalid <= 1'b0;
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && expected_faces.size() == 0)
            $display("voxel_face_culling_tb OK");
        else
            $display("voxel_face_culling_tb NOT OK");
        $finish;
    end

endmodule

// ===== voxel_face_culling.f =====
+incdir+rtl/core
rtl/core/vfc_pkg.sv
rtl/core/vfc_front.sv
rtl/core/vfc_queue.sv
rtl/core/vfc_back.sv
rtl/core/voxel_face_culling.sv
tb/sv/voxel_face_culling_tb.sv
